[hdl/skt_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_pkg: shared types and constants for the sorted key table
// Entry, request and result layouts, request kinds and status codes.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [1:0] KIND_ADD    = 2'd0;
  localparam logic [1:0] KIND_REMOVE = 2'd1;
  localparam logic [1:0] KIND_LOOKUP = 2'd2;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] group_id;
    logic [15:0] class_code;
    logic [7:0]  level_byte;
    logic [31:0] server_id;
  } skt_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] found_group_id;
    logic [15:0] found_class;
    logic [7:0]  found_level;
    logic [31:0] found_server_id;
    logic [6:0]  entry_count;
  } skt_out_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] group_id;
    logic [15:0] class_code;
    logic [7:0]  level_byte;
    logic [31:0] server_id;
  } skt_entry_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } skt_cmp_t;

endpackage : skt_pkg
`default_nettype wire

[hdl/sorted_key_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_key_table: bounded table of entries kept in ascending key order
// Add, remove and lookup by a 32-bit key, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one request transaction (kind, key, payload).
//   out_valid/out_ready return one result transaction per request: status,
//   looked-up payload (zero unless a lookup hits) and the entry count.
// Timing:
//   A request walks the table once, one entry per cycle, through the entry
//   RAM read port and the single key comparator. Add and remove move the
//   tail entries during the same walk. A lookup walk ends early on a
//   match or a larger key, a remove walk on a larger key and an add walk
//   on a match. A full-table add or an unused kind skips the walk and goes
//   straight to the result state. One request is worked on at a time;
//   in_ready is high only while the sequencer is idle.
// Reset:
//   The table is empty after reset; entry RAM contents are not cleared.
// Stall:
//   The result sits in an output register; the next request is accepted
//   while it waits, and its result is held back until out_ready frees it.
// ----------------------------------------------------------------------------
module sorted_key_table (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire skt_pkg::skt_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output skt_pkg::skt_out_t     out_data
);
  import skt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_WALK,
    S_FIN,
    S_RESP
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              out_valid_r, out_valid_nxt;
  skt_out_t          out_data_r, out_data_nxt;
  skt_in_t           req_r, req_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic              past_r, past_nxt;
  skt_entry_t        hold_r, hold_nxt;
  skt_entry_t        found_r, found_nxt;
  logic [1:0]        status_r, status_nxt;

  logic              we_c;
  logic [IDX_W-1:0]  waddr_c;
  skt_entry_t        wdata_c;
  logic [IDX_W-1:0]  raddr_c;
  skt_entry_t        rdata;
  skt_entry_t        new_entry;
  skt_cmp_t          cmp;
  logic              last_c;
  logic              done_c;
  logic [CNT_W+6:0]  count_ext;

  skt_entry_ram u_ram (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  skt_key_cmp u_cmp (
    .stored_key (rdata.key),
    .req_key    (req_r.key),
    .result     (cmp)
  );

  always_comb begin
    new_entry.key        = req_r.key;
    new_entry.group_id   = req_r.group_id;
    new_entry.class_code = req_r.class_code;
    new_entry.level_byte = req_r.level_byte;
    new_entry.server_id  = req_r.server_id;
    last_c    = ((CNT_W'(idx_r) + CNT_W'(1)) == count_r);
    count_ext = {7'd0, count_r};
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    out_data_nxt  = out_data_r;
    req_nxt       = req_r;
    idx_nxt       = idx_r;
    past_nxt      = past_r;
    hold_nxt      = hold_r;
    found_nxt     = found_r;
    status_nxt    = status_r;
    we_c          = 1'b0;
    waddr_c       = idx_r;
    wdata_c       = new_entry;
    raddr_c       = idx_r + IDX_W'(1);
    done_c        = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        raddr_c = '0;
        if (in_valid) begin
          req_nxt   = in_data;
          idx_nxt   = '0;
          past_nxt  = 1'b0;
          found_nxt = '0;
          if (in_data.kind == KIND_ADD && count_r == CNT_W'(CAPACITY)) begin
            status_nxt = ST_FULL;
            state_nxt  = S_RESP;
          end else if (in_data.kind == KIND_UNUSED) begin
            status_nxt = ST_NOT_FOUND;
            state_nxt  = S_RESP;
          end else begin
            state_nxt = S_START;
          end
        end
      end

      S_START: begin
        raddr_c = '0;
        idx_nxt = '0;
        state_nxt = (count_r == '0) ? S_FIN : S_WALK;
      end

      S_WALK: begin
        idx_nxt = idx_r + IDX_W'(1);
        unique case (req_r.kind)
          KIND_ADD: begin
            if (past_r) begin
              // shift the held entry up one place
              we_c     = 1'b1;
              wdata_c  = hold_r;
              hold_nxt = rdata;
            end else if (cmp.eq) begin
              we_c       = 1'b1;
              status_nxt = ST_OK;
              done_c     = 1'b1;
            end else if (!cmp.lt) begin
              we_c     = 1'b1;
              hold_nxt = rdata;
              past_nxt = 1'b1;
            end
          end
          KIND_REMOVE: begin
            if (past_r) begin
              // pull the entry down over the removed slot
              we_c    = 1'b1;
              waddr_c = idx_r - IDX_W'(1);
              wdata_c = rdata;
            end else if (cmp.eq) begin
              past_nxt = 1'b1;
            end else if (!cmp.lt) begin
              status_nxt = ST_NOT_FOUND;
              done_c     = 1'b1;
            end
          end
          KIND_LOOKUP: begin
            if (cmp.eq) begin
              found_nxt  = rdata;
              status_nxt = ST_OK;
              done_c     = 1'b1;
            end else if (!cmp.lt) begin
              status_nxt = ST_NOT_FOUND;
              done_c     = 1'b1;
            end
          end
          default: begin
            status_nxt = ST_NOT_FOUND;
            done_c     = 1'b1;
          end
        endcase
        if (done_c) begin
          state_nxt = S_RESP;
        end else if (last_c) begin
          state_nxt = S_FIN;
        end
      end

      S_FIN: begin
        unique case (req_r.kind)
          KIND_ADD: begin
            we_c       = 1'b1;
            waddr_c    = count_r[IDX_W-1:0];
            wdata_c    = past_r ? hold_r : new_entry;
            count_nxt  = count_r + CNT_W'(1);
            status_nxt = ST_OK;
          end
          KIND_REMOVE: begin
            if (past_r) begin
              count_nxt  = count_r - CNT_W'(1);
              status_nxt = ST_OK;
            end else begin
              status_nxt = ST_NOT_FOUND;
            end
          end
          default: begin
            status_nxt = ST_NOT_FOUND;
          end
        endcase
        state_nxt = S_RESP;
      end

      S_RESP: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt.status          = status_r;
          out_data_nxt.found_group_id  = found_r.group_id;
          out_data_nxt.found_class     = found_r.class_code;
          out_data_nxt.found_level     = found_r.level_byte;
          out_data_nxt.found_server_id = found_r.server_id;
          out_data_nxt.entry_count     = count_ext[6:0];
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
    req_r      <= req_nxt;
    idx_r      <= idx_nxt;
    past_r     <= past_nxt;
    hold_r     <= hold_nxt;
    found_r    <= found_nxt;
    status_r   <= status_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_walk_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> count_r != '0)
    else $error("walk started on an empty table");

  a_write_phase: assert property (@(posedge clk) disable iff (!rst_n)
    we_c |-> (state_r == S_WALK || state_r == S_FIN))
    else $error("entry write outside the walk");

  a_add_room: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN && req_r.kind == KIND_ADD) |-> count_r < CNT_W'(CAPACITY))
    else $error("insert into a full table");

endmodule : sorted_key_table
`default_nettype wire

[hdl/skt_entry_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_entry_ram: entry storage
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module skt_entry_ram (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [skt_pkg::IDX_W-1:0] waddr,
  input  wire skt_pkg::skt_entry_t       wdata,
  input  wire logic [skt_pkg::IDX_W-1:0] raddr,
  output skt_pkg::skt_entry_t            rdata
);
  import skt_pkg::*;

  skt_entry_t mem [CAPACITY];
  skt_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule : skt_entry_ram
`default_nettype wire

[hdl/skt_key_cmp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skt_key_cmp: key comparator
// Shared magnitude compare of a stored key against the request key.
// ----------------------------------------------------------------------------
module skt_key_cmp (
  input  wire logic [31:0] stored_key,
  input  wire logic [31:0] req_key,
  output skt_pkg::skt_cmp_t result
);
  import skt_pkg::*;

  always_comb begin
    result.lt = (stored_key < req_key);
    result.eq = (stored_key == req_key);
  end

endmodule : skt_key_cmp
`default_nettype wire

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the sorted key table
// A directed set of requests is followed by randomized fill, mixed and drain
// sequences over a shared key pool. Each request is predicted by a shadow
// table as it is accepted, and every result transaction is checked field by
// field against the prediction. The run steps through several idle and stall
// patterns on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import skt_pkg::*;

  localparam int POOL_N = 72;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_ready;
  skt_in_t  in_data = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  skt_out_t out_data;

  sorted_key_table i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // shadow copy of the table, kept in ascending key order
  skt_entry_t  shadow_rows [CAPACITY];
  int          row_count = 0;
  int          peak_rows = 0;

  skt_in_t     request_queue [$];
  skt_out_t    expected_results [$];
  logic [31:0] key_pool [POOL_N];

  int send_gap_pct = 0;
  int recv_stall_pct = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_ok = 0;
  int n_missing = 0;
  int n_full = 0;

  function automatic skt_out_t predict_result(skt_in_t req);
    skt_out_t res;
    int       pos;
    int       i;
    bit       hit;
    res = '0;
    res.status = ST_NOT_FOUND;
    pos = 0;
    while (pos < row_count && shadow_rows[pos].key < req.key) pos++;
    hit = (pos < row_count) && (shadow_rows[pos].key == req.key);
    case (req.kind)
      KIND_ADD: begin
        if (row_count >= CAPACITY) begin
          res.status = ST_FULL;
        end else begin
          if (!hit) begin
            for (i = row_count; i > pos; i--) shadow_rows[i] = shadow_rows[i-1];
            row_count++;
          end
          shadow_rows[pos] = '{key: req.key, group_id: req.group_id,
                               class_code: req.class_code,
                               level_byte: req.level_byte,
                               server_id: req.server_id};
          res.status = ST_OK;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          for (i = pos; i + 1 < row_count; i++) shadow_rows[i] = shadow_rows[i+1];
          row_count--;
          res.status = ST_OK;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          res.found_group_id  = shadow_rows[pos].group_id;
          res.found_class     = shadow_rows[pos].class_code;
          res.found_level     = shadow_rows[pos].level_byte;
          res.found_server_id = shadow_rows[pos].server_id;
          res.status = ST_OK;
        end
      end
      default: ;
    endcase
    if (row_count > peak_rows) peak_rows = row_count;
    res.entry_count = 7'(row_count);
    return res;
  endfunction

  function automatic skt_in_t make_req(logic [1:0] kind, logic [31:0] key);
    skt_in_t req;
    req.kind       = kind;
    req.key        = key;
    req.group_id   = $urandom();
    req.class_code = 16'($urandom());
    req.level_byte = 8'($urandom());
    req.server_id  = $urandom();
    return req;
  endfunction

  function automatic skt_in_t fixed_req(logic [1:0] kind, logic [31:0] key,
                                        logic [7:0] fill);
    skt_in_t req;
    req.kind       = kind;
    req.key        = key;
    req.group_id   = {4{fill}};
    req.class_code = {2{fill}};
    req.level_byte = fill;
    req.server_id  = {4{fill}};
    return req;
  endfunction

  task automatic shuffle_pool();
    int          j;
    logic [31:0] tmp;
    for (int i = POOL_N - 1; i > 0; i--) begin
      j = $urandom_range(i);
      tmp = key_pool[i];
      key_pool[i] = key_pool[j];
      key_pool[j] = tmp;
    end
  endtask

  function automatic logic [31:0] pick_key();
    if ($urandom_range(99) < 80) return key_pool[$urandom_range(POOL_N - 1)];
    return $urandom();
  endfunction

  // fill burst, mixed traffic, drain burst, then a little noise
  task automatic queue_phase(int fill_n);
    int         r;
    logic [1:0] kind;
    shuffle_pool();
    for (int i = 0; i < fill_n; i++)
      request_queue.push_back(make_req(KIND_ADD, key_pool[i % POOL_N]));
    for (int i = 0; i < 30; i++) begin
      r = $urandom_range(99);
      if (r < 40)      kind = KIND_ADD;
      else if (r < 65) kind = KIND_REMOVE;
      else if (r < 95) kind = KIND_LOOKUP;
      else             kind = KIND_UNUSED;
      request_queue.push_back(make_req(kind, pick_key()));
    end
    shuffle_pool();
    for (int i = 0; i < 20; i++)
      request_queue.push_back(make_req(KIND_REMOVE, key_pool[i]));
    for (int i = 0; i < 6; i++)
      request_queue.push_back(make_req(2'($urandom_range(3)), $urandom()));
  endtask

  // hold further stimulus until every queued request has produced its result
  task automatic wait_idle();
    @(negedge clk);
    while (request_queue.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  task automatic report_mismatch(string field, logic [31:0] want_v, logic [31:0] got_v);
    $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want_v, got_v);
    n_errors++;
  endtask

  // driver: predict on each accepted transaction, then present the next one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) expected_results.push_back(predict_result(in_data));
      if (!in_valid || in_ready) begin
        if (request_queue.size() > 0 && $urandom_range(99) >= send_gap_pct) begin
          in_valid <= 1'b1;
          in_data <= request_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: compare each result transaction with the oldest prediction
  always @(posedge clk) begin : result_monitor
    skt_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %p", $time, out_data);
          n_errors++;
        end else begin
          want = expected_results.pop_front();
          n_checked++;
          if (want.status == ST_OK) n_ok++;
          else if (want.status == ST_FULL) n_full++;
          else n_missing++;
          if (out_data.status !== want.status)
            report_mismatch("status", 32'(want.status), 32'(out_data.status));
          if (out_data.found_group_id !== want.found_group_id)
            report_mismatch("found_group_id", want.found_group_id, out_data.found_group_id);
          if (out_data.found_class !== want.found_class)
            report_mismatch("found_class", 32'(want.found_class), 32'(out_data.found_class));
          if (out_data.found_level !== want.found_level)
            report_mismatch("found_level", 32'(want.found_level), 32'(out_data.found_level));
          if (out_data.found_server_id !== want.found_server_id)
            report_mismatch("found_server_id", want.found_server_id,
                            out_data.found_server_id);
          if (out_data.entry_count !== want.entry_count)
            report_mismatch("entry_count", 32'(want.entry_count),
                            32'(out_data.entry_count));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    key_pool[0] = 32'h0000_0000;
    key_pool[1] = 32'hFFFF_FFFF;
    key_pool[2] = 32'h0000_0001;
    key_pool[3] = 32'hFFFF_FFFE;
    for (int i = 4; i < POOL_N; i++) key_pool[i] = $urandom();

    wait (rst_n === 1'b1);
    @(negedge clk);

    // directed: empty table, extremes, insert order, update, misses, unused kind
    request_queue.push_back(fixed_req(KIND_LOOKUP, 32'h0000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_REMOVE, 32'hFFFF_FFFF, 8'hFF));
    request_queue.push_back(fixed_req(KIND_UNUSED, 32'hFFFF_FFFF, 8'hFF));
    request_queue.push_back(fixed_req(KIND_ADD, 32'hFFFF_FFFF, 8'hFF));
    request_queue.push_back(fixed_req(KIND_ADD, 32'h0000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_ADD, 32'h8000_0000, 8'h5A));
    request_queue.push_back(fixed_req(KIND_ADD, 32'h0000_0001, 8'hA5));
    request_queue.push_back(fixed_req(KIND_LOOKUP, 32'hFFFF_FFFF, 8'h00));
    request_queue.push_back(fixed_req(KIND_LOOKUP, 32'h0000_0000, 8'hFF));
    request_queue.push_back(fixed_req(KIND_LOOKUP, 32'h7FFF_FFFF, 8'h00));
    request_queue.push_back(fixed_req(KIND_ADD, 32'h0000_0000, 8'hFF));
    request_queue.push_back(fixed_req(KIND_LOOKUP, 32'h0000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_REMOVE, 32'h8000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_REMOVE, 32'h8000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_LOOKUP, 32'h0000_0001, 8'h00));
    request_queue.push_back(fixed_req(KIND_UNUSED, 32'h0000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_REMOVE, 32'h0000_0000, 8'h00));
    request_queue.push_back(fixed_req(KIND_REMOVE, 32'h0000_0001, 8'h00));
    request_queue.push_back(fixed_req(KIND_REMOVE, 32'hFFFF_FFFF, 8'h00));
    wait_idle();

    // full-pool fills push the table past capacity in the first and third phase
    queue_phase(POOL_N);
    wait_idle();
    send_gap_pct = 69;
    queue_phase(30);
    wait_idle();
    send_gap_pct = 0;
    recv_stall_pct = 69;
    queue_phase(POOL_N);
    wait_idle();
    send_gap_pct = 16;
    recv_stall_pct = 16;
    queue_phase(40);
    wait_idle();

    repeat (80) @(posedge clk);
    $display("Checked %0d results: %0d ok, %0d key not found, %0d refused on full table",
             n_checked, n_ok, n_missing, n_full);
    $display("Peak table occupancy %0d of %0d entries over four idle/stall patterns",
             peak_rows, CAPACITY);
    if (n_errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
